// ----- rtl/tsr_pkg.sv -----
// Shared types and constants for the transport stream section reassembler.
// No dependencies; the top level refers to this package by scoped names.
package tsr_pkg;

    localparam int STORE_DEPTH_DEF = 8192;

    localparam logic [7:0]  PACKET_BYTES = 8'd188;
    localparam logic [12:0] PID_RESET    = 13'd18;
    localparam logic [3:0]  CC_RESET     = 4'hf;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic KIND_SECTION = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  ts_byte;
        logic        packet_start;
        logic [12:0] read_offset;
    } in_beat_t;

    typedef struct packed {
        logic        result_kind;
        logic [12:0] sect_len_out;
        logic [7:0]  read_data;
    } out_beat_t;

endpackage

// ----- rtl/tsr_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- rtl/ts_section_reassembler.sv -----
// Top level of the transport stream PSI section reassembler.
// Depends on tsr_pkg and tsr_ram.
//
//   Port group   Direction  Handshake          Beat
//   cfg_wr_*     in         enable only        PID filter value
//   s_*          in         s_valid / s_ready  tsr_pkg::in_beat_t
//   m_*          out        m_valid / m_ready  tsr_pkg::out_beat_t
//
// One beat is accepted per cycle while s_ready is high; a read result or a section result is
// registered as a pending result and then written into a four-entry output queue.
// After a section completes at a packet end with leftover bytes kept, s_ready drops while the
// header bytes of the next section are fetched from the section store in the fetch states.
// s_ready also drops when the output queue would overflow. Reset is synchronous and needs no
// clearing pass; the section store content is undefined until written.
module ts_section_reassembler #(
    parameter int STORE_DEPTH = tsr_pkg::STORE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [12:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsr_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tsr_pkg::out_beat_t  m_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    localparam logic [3:0] PH_SKIP    = 4'd0;
    localparam logic [3:0] PH_WAIT_AF = 4'd1;
    localparam logic [3:0] PH_WAIT_DC = 4'd2;
    localparam logic [3:0] PH_PAYLOAD = 4'd3;
    localparam logic [3:0] PH_BEFORE  = 4'd4;
    localparam logic [3:0] PH_AFTER   = 4'd5;
    localparam logic [3:0] PH_COPY    = 4'd6;
    localparam logic [3:0] PH_LOST    = 4'd7;
    localparam logic [3:0] PH_HDR     = 4'd8;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HDR  = 2'd1;
    localparam logic [1:0] F_LEN  = 2'd2;
    localparam logic [1:0] F_NB   = 2'd3;

    logic [12:0]   pid_reg;
    logic [AW-1:0] base_reg, base_next;
    logic [12:0]   fill_reg, fill_next;
    logic [3:0]    last_cc_reg, last_cc_next;
    logic          start_seen_reg, start_seen_next;
    logic [7:0]    bi_reg, bi_next;
    logic [7:0]    hf_hi_reg, hf_hi_next;
    logic [3:0]    cc_reg, cc_next;
    logic [7:0]    pc_reg, pc_next;
    logic [7:0]    br_reg, br_next;
    logic [3:0]    phase_reg, phase_next;
    logic [7:0]    h1_reg, h1_next, h2_reg, h2_next, nb_reg, nb_next;
    logic [1:0]    fetch_reg, fetch_next;

    logic          p_v_reg, p_v_next;
    logic          p_kind_reg, p_kind_next;
    logic [12:0]   p_len_reg, p_len_next;

    tsr_pkg::out_beat_t q_mem_reg [4];
    logic [1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [2:0]    cnt_reg;

    logic          accept, push, pop;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [7:0]    ram_q_a, ram_q_b;

    tsr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (s_data.ts_byte),
        .rd_addr_a (ram_raddr_a),
        .rd_data_a (ram_q_a),
        .rd_addr_b (ram_raddr_b),
        .rd_data_b (ram_q_b)
    );

    assign accept  = s_valid && s_ready;
    assign s_ready = (fetch_reg == F_IDLE) && (({1'b0, cnt_reg} + {3'b000, p_v_reg}) <= 4'd2);
    assign push    = p_v_reg;
    assign m_valid = (cnt_reg != 3'd0);
    assign pop     = m_valid && m_ready;
    assign m_data  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        logic [7:0]  b;
        logic [7:0]  i;
        logic        act;
        logic        app;
        logic        do_dec;
        logic        dc;
        logic        run_end;
        logic        chk_before;
        logic        chk_end;
        logic        got;
        logic        keep;
        logic [3:0]  cc_sel;
        logic [12:0] f;
        logic [12:0] len_pre;
        logic [12:0] len_e;
        logic [12:0] len_q;
        logic [12:0] rem;
        logic [7:0]  h1;
        logic [7:0]  h2;
        logic [7:0]  nb;

        base_next       = base_reg;
        fill_next       = fill_reg;
        last_cc_next    = last_cc_reg;
        start_seen_next = start_seen_reg;
        bi_next         = bi_reg;
        hf_hi_next      = hf_hi_reg;
        cc_next         = cc_reg;
        pc_next         = pc_reg;
        br_next         = br_reg;
        phase_next      = phase_reg;
        fetch_next      = fetch_reg;

        b          = s_data.ts_byte;
        i          = s_data.packet_start ? 8'd0 : bi_reg;
        act        = accept && (s_data.func == tsr_pkg::FUNC_PUSH)
                     && (s_data.packet_start || (bi_reg < tsr_pkg::PACKET_BYTES));
        app        = 1'b0;
        do_dec     = 1'b0;
        dc         = 1'b0;
        run_end    = 1'b0;
        chk_before = 1'b0;
        chk_end    = 1'b0;

        if (act) begin
            bi_next = i + 8'd1;
            if (i == 8'd0) begin
                phase_next = PH_HDR;
            end else if (i == 8'd1) begin
                hf_hi_next = b;
            end else if (i == 8'd2) begin
                if ({hf_hi_reg[4:0], b} != pid_reg) begin
                    phase_next = PH_SKIP;
                end
            end else if (phase_reg == PH_SKIP) begin
                phase_next = PH_SKIP;
            end else if (i == 8'd3) begin
                cc_next = b[3:0];
                if ((b[7:6] != 2'b00) || hf_hi_reg[7]) begin
                    fill_next  = 13'd0;
                    phase_next = PH_SKIP;
                end else if (!b[4]) begin
                    phase_next = PH_SKIP;
                end else if (!b[5]) begin
                    pc_next = 8'd184;
                    do_dec  = 1'b1;
                end else begin
                    phase_next = PH_WAIT_AF;
                end
            end else if (phase_reg == PH_WAIT_AF) begin
                if (b >= 8'd183) begin
                    phase_next = PH_SKIP;
                end else begin
                    pc_next = 8'd183 - b;
                    if (b == 8'd0) begin
                        do_dec = 1'b1;
                    end else begin
                        phase_next = PH_WAIT_DC;
                    end
                end
            end else if (phase_reg == PH_WAIT_DC) begin
                do_dec = 1'b1;
                dc     = b[7];
            end else begin
                run_end = 1'b1;
                case (phase_reg)
                    PH_PAYLOAD: begin
                        if (i < (tsr_pkg::PACKET_BYTES - pc_reg)) begin
                            run_end = 1'b0;
                        end else if (hf_hi_reg[6]) begin
                            if ((pc_reg > 8'd1) && (b < pc_reg)) begin
                                br_next    = b;
                                phase_next = PH_BEFORE;
                                chk_before = (b == 8'd0);
                            end else begin
                                phase_next = PH_LOST;
                            end
                        end else if (start_seen_reg) begin
                            phase_next = PH_COPY;
                            app        = 1'b1;
                        end else begin
                            fill_next  = 13'd0;
                            phase_next = PH_LOST;
                        end
                    end
                    PH_BEFORE: begin
                        app        = 1'b1;
                        br_next    = br_reg - 8'd1;
                        chk_before = (br_reg == 8'd1);
                    end
                    PH_AFTER, PH_COPY: begin
                        app = 1'b1;
                    end
                    default: begin
                        app = 1'b0;
                    end
                endcase
                chk_end = run_end && (i == (tsr_pkg::PACKET_BYTES - 8'd1)) && !chk_before;
            end
        end

        cc_sel = (i == 8'd3) ? b[3:0] : cc_reg;
        if (do_dec) begin
            last_cc_next = cc_sel;
            if (((last_cc_reg + 4'd1) != cc_sel) || dc) begin
                start_seen_next = 1'b0;
                fill_next       = 13'd0;
            end
            phase_next = PH_PAYLOAD;
        end

        // Header bytes and the byte after the section are mirrored as they are stored.
        f       = fill_reg;
        h1      = h1_reg;
        h2      = h2_reg;
        nb      = nb_reg;
        len_pre = 13'd3 + {1'b0, h1_reg[3:0], h2_reg};
        if (app) begin
            if (f == 13'd1) begin
                h1 = b;
            end
            if (f == 13'd2) begin
                h2 = b;
            end
            if ((f > 13'd2) && (f == len_pre)) begin
                nb = b;
            end
            f         = f + 13'd1;
            fill_next = f;
        end
        ram_we    = app;
        ram_waddr = base_reg + AW'(fill_reg);

        len_e = 13'd3 + {1'b0, h1[3:0], h2};
        rem   = f - len_e;
        got   = (chk_before || chk_end) && (f > 13'd2) && (f >= len_e);
        keep  = chk_end && (rem != 13'd0) && (nb != 8'hff);
        if (got) begin
            base_next = base_reg + AW'(len_e);
            fill_next = keep ? rem : 13'd0;
            if (keep) begin
                fetch_next = F_HDR;
            end
        end
        if (chk_before) begin
            start_seen_next = 1'b1;
            fill_next       = 13'd0;
            phase_next      = PH_AFTER;
        end
        h1_next = h1;
        h2_next = h2;
        nb_next = nb;

        p_v_next    = accept && ((s_data.func == tsr_pkg::FUNC_READ) || got);
        p_kind_next = (s_data.func == tsr_pkg::FUNC_READ) ? tsr_pkg::KIND_READ
                                                         : tsr_pkg::KIND_SECTION;
        p_len_next  = (s_data.func == tsr_pkg::FUNC_READ) ? 13'd0 : len_e;

        ram_raddr_a = base_reg + AW'(s_data.read_offset);
        ram_raddr_b = base_reg + AW'(13'd2);
        len_q       = 13'd3 + {1'b0, ram_q_a[3:0], ram_q_b};
        case (fetch_reg)
            F_HDR: begin
                ram_raddr_a = base_reg + AW'(13'd1);
                fetch_next  = F_LEN;
            end
            F_LEN: begin
                h1_next     = ram_q_a;
                h2_next     = ram_q_b;
                ram_raddr_b = base_reg + AW'(len_q);
                fetch_next  = F_NB;
            end
            F_NB: begin
                nb_next    = ram_q_b;
                fetch_next = F_IDLE;
            end
            default: begin
                fetch_next = fetch_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pid_reg        <= tsr_pkg::PID_RESET;
            base_reg       <= '0;
            fill_reg       <= 13'd0;
            last_cc_reg    <= tsr_pkg::CC_RESET;
            start_seen_reg <= 1'b0;
            bi_reg         <= tsr_pkg::PACKET_BYTES;
            hf_hi_reg      <= 8'd0;
            cc_reg         <= 4'd0;
            pc_reg         <= 8'd0;
            br_reg         <= 8'd0;
            phase_reg      <= PH_SKIP;
            fetch_reg      <= F_IDLE;
            p_v_reg        <= 1'b0;
            wr_ptr_reg     <= 2'd0;
            rd_ptr_reg     <= 2'd0;
            cnt_reg        <= 3'd0;
        end else begin
            if (cfg_wr_en) begin
                pid_reg <= cfg_wr_data;
            end
            base_reg       <= base_next;
            fill_reg       <= fill_next;
            last_cc_reg    <= last_cc_next;
            start_seen_reg <= start_seen_next;
            bi_reg         <= bi_next;
            hf_hi_reg      <= hf_hi_next;
            cc_reg         <= cc_next;
            pc_reg         <= pc_next;
            br_reg         <= br_next;
            phase_reg      <= phase_next;
            fetch_reg      <= fetch_next;
            p_v_reg        <= p_v_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'b00, push} - {2'b00, pop};
        end
    end

    always_ff @(posedge aclk) begin
        h1_reg     <= h1_next;
        h2_reg     <= h2_next;
        nb_reg     <= nb_next;
        p_kind_reg <= p_kind_next;
        p_len_reg  <= p_len_next;
        if (push) begin
            q_mem_reg[wr_ptr_reg].result_kind  <= p_kind_reg;
            q_mem_reg[wr_ptr_reg].sect_len_out <= p_len_reg;
            q_mem_reg[wr_ptr_reg].read_data    <= p_kind_reg ? ram_q_a : 8'h00;
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("Output queue overflow.");

    a_fetch_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (fetch_reg != F_IDLE) |-> !s_ready)
        else $error("Beat accepted during a header fetch.");

    a_section_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.result_kind == tsr_pkg::KIND_SECTION))
            |-> (m_data.sect_len_out >= 13'd3))
        else $error("Section result shorter than its header.");

    a_fetch_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fetch_reg == F_HDR) |-> (fill_reg != 13'd0))
        else $error("Header fetch started with an empty buffer.");

endmodule
